// ===== sv/cdss_pkg.sv =====
package cdss_pkg;

  localparam int VW  = 32;
  localparam int IW  = 48;
  localparam int MAW = 48;
  localparam int MBW = 34;
  localparam int PW  = MAW + MBW;
  localparam int NW  = 64;
  localparam int DW  = 36;
  localparam int CW  = 6;

  localparam logic [NW-1:0]  Y_NUM     = 64'd5954088944;
  localparam logic [MBW-1:0] C048      = 34'd31457;
  localparam logic [MBW-1:0] C0235     = 34'd15401;
  localparam logic [46:0]    LIM47     = 47'h7FFF_FFFF_FFFF;
  localparam logic [20:0]    HL_RESET  = 21'd13107;
  localparam logic signed [IW-1:0] X_MAX = 48'sd8388608;
  localparam logic           REG_HALFLIFE = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE, ST_Y, ST_X, ST_X2, ST_X3, ST_C1, ST_C2, ST_DEN, ST_E,
    ST_J0, ST_M1, ST_M2, ST_D0, ST_D1, ST_D2, ST_D3, ST_M3,
    ST_P1, ST_P2, ST_P3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_WB, ST_OUT
  } state_t;

  function automatic logic signed [IW-1:0] sat48(input logic signed [IW:0] v);
    logic signed [IW:0] lim;
    lim = $signed({2'b00, LIM47});
    if (v > lim) return $signed({1'b0, LIM47});
    if (v < -lim) return -$signed({1'b0, LIM47});
    return v[IW-1:0];
  endfunction

  function automatic logic signed [IW-1:0] add_sat(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    logic signed [IW:0] s;
    s = (IW+1)'(a) + (IW+1)'(b);
    return sat48(s);
  endfunction

  function automatic logic signed [IW-1:0] sub_sat(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    logic signed [IW:0] s;
    s = (IW+1)'(a) - (IW+1)'(b);
    return sat48(s);
  endfunction

  function automatic logic signed [VW-1:0] sat32(input logic signed [IW-1:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return v[VW-1:0];
  endfunction

  function automatic logic [46:0] mag47(input logic signed [IW-1:0] v);
    logic [IW-1:0] m;
    m = v[IW-1] ? -v : v;
    return m[46:0];
  endfunction

endpackage

// ===== sv/critically_damped_spring_step.sv =====
// One item is in flight at a time: a new input beat is taken only while the sequencer is
// idle, and in_stall stays high until the result is loaded into the output registers.
// When the damping term underflows to zero, the steps that compute it are skipped.
// The work is done by one shared unit that multiplies one bit per cycle and
// divides one quotient bit per cycle, stepped by the sequencer.
// Synchronous active-low reset clears the state vectors to zero and sets the
// halflife register to 0.2 s.
module critically_damped_spring_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_desired_vel_x,
  input  logic signed [31:0] in_desired_vel_y,
  input  logic signed [31:0] in_desired_vel_z,
  input  logic [16:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic signed [31:0] out_acc_x,
  output logic signed [31:0] out_acc_y,
  output logic signed [31:0] out_acc_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cdss_pkg::*;

  state_t state_r, state_nxt;
  logic   issued_r, issued_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [20:0] halflife_r;
  logic [21:0] h1;

  logic signed [VW-1:0] dv_r [3];
  logic [16:0] dt_r;
  logic signed [VW-1:0] pos_r [3];
  logic signed [VW-1:0] vel_r [3];
  logic signed [VW-1:0] acc_r [3];
  logic signed [VW-1:0] opos_r [3];
  logic signed [VW-1:0] ovel_r [3];
  logic signed [VW-1:0] oacc_r [3];
  logic out_valid_r, out_valid_nxt;

  logic [32:0] y_r, y_nxt;
  logic [34:0] x_r, x_nxt;
  logic [16:0] e_r, e_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic signed [IW-1:0] j0_r, j0_nxt, j1_r, j1_nxt, k_r, k_nxt;
  logic signed [IW-1:0] t0_r, t0_nxt, t1_r, t1_nxt, tk_r, tk_nxt;
  logic signed [IW-1:0] np_r, np_nxt, nv_r, nv_nxt, tmp_r, tmp_nxt;

  logic in_acc, wb_en, load_out, is_op, use_src;
  logic signed [IW-1:0] src, cur_dv, cur_p, cur_v, cur_a;

  // Shared multiply / divide unit.
  logic u_start, u_div, u_neg;
  logic [NW-1:0] u_num;
  logic [DW-1:0] u_b;
  logic busy_r, done_r, kind_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] mcand_r, prod_r;
  logic [MBW-1:0] mplier_r;
  logic [NW-1:0] num_r, quo_r;
  logic [DW-1:0] dd_r, rem_r;
  logic [DW:0] trial;
  logic ge;
  logic [PW:0] rsum;
  logic [66:0] rq;
  logic [46:0] umag;
  logic signed [IW-1:0] res;

  assign h1 = 22'(halflife_r) + 22'd1;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HALFLIFE) ? 32'(halflife_r) : 32'd0;

  assign trial = {rem_r, num_r[NW-1]};
  assign ge = trial >= {1'b0, dd_r};
  assign rsum = {1'b0, prod_r} + (PW+1)'(32768);
  assign rq = kind_r ? 67'(quo_r) : rsum[PW:16];
  assign umag = (rq > 67'(LIM47)) ? LIM47 : rq[46:0];
  assign res = neg_r ? -$signed({1'b0, umag}) : $signed({1'b0, umag});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (u_start) begin
        busy_r   <= 1'b1;
        kind_r   <= u_div;
        neg_r    <= u_neg;
        cnt_r    <= u_div ? CW'(NW-1) : CW'(MBW-1);
        mcand_r  <= PW'(u_num[MAW-1:0]);
        mplier_r <= u_b[MBW-1:0];
        prod_r   <= '0;
        num_r    <= u_num;
        dd_r     <= u_b;
        rem_r    <= '0;
        quo_r    <= '0;
      end else if (busy_r) begin
        if (kind_r) begin
          rem_r <= ge ? DW'(trial - {1'b0, dd_r}) : trial[DW-1:0];
          quo_r <= {quo_r[NW-2:0], ge};
          num_r <= num_r << 1;
        end else begin
          if (mplier_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    issued_nxt = issued_r;
    ax_nxt = ax_r;
    y_nxt = y_r;
    x_nxt = x_r;
    e_nxt = e_r;
    den_nxt = den_r;
    j0_nxt = j0_r;
    j1_nxt = j1_r;
    k_nxt = k_r;
    t0_nxt = t0_r;
    t1_nxt = t1_r;
    tk_nxt = tk_r;
    np_nxt = np_r;
    nv_nxt = nv_r;
    tmp_nxt = tmp_r;
    wb_en = 1'b0;
    load_out = 1'b0;
    u_start = 1'b0;
    u_div = 1'b0;
    u_neg = 1'b0;
    u_num = '0;
    u_b = '0;
    use_src = 1'b0;
    src = '0;
    cur_dv = IW'(dv_r[ax_r]);
    cur_p = IW'(pos_r[ax_r]);
    cur_v = IW'(vel_r[ax_r]);
    cur_a = IW'(acc_r[ax_r]);
    is_op = state_r inside {ST_Y, ST_X, ST_X2, ST_X3, ST_C1, ST_C2, ST_E, ST_M1, ST_M2,
                            ST_D0, ST_D1, ST_D2, ST_D3, ST_M3, ST_M4, ST_M5, ST_M6,
                            ST_M7, ST_M8};

    case (state_r)
      ST_Y: begin
        u_div = 1'b1;
        u_num = Y_NUM + 64'(h1[21:1]);
        u_b = DW'(h1);
      end
      ST_X: begin
        u_num = 64'(y_r);
        u_b = DW'(dt_r);
      end
      ST_X2: begin
        u_num = 64'(x_r[22:0]);
        u_b = DW'(x_r[22:0]);
      end
      ST_X3: begin
        use_src = 1'b1;
        src = t0_r;
        u_b = DW'(x_r[22:0]);
      end
      ST_C1: begin
        use_src = 1'b1;
        src = t0_r;
        u_b = DW'(C048);
      end
      ST_C2: begin
        use_src = 1'b1;
        src = t1_r;
        u_b = DW'(C0235);
      end
      ST_E: begin
        u_div = 1'b1;
        u_num = 64'h1_0000_0000 + 64'(den_r[DW-1:1]);
        u_b = den_r;
      end
      ST_M1: begin
        use_src = 1'b1;
        src = j0_r;
        u_b = DW'(y_r);
      end
      ST_M2: begin
        use_src = 1'b1;
        src = j1_r;
        u_b = DW'(dt_r);
      end
      ST_D0: begin
        use_src = 1'b1;
        u_div = 1'b1;
        src = j0_r;
        u_b = DW'(y_r);
      end
      ST_D1: begin
        use_src = 1'b1;
        u_div = 1'b1;
        src = j1_r;
        u_b = DW'(y_r);
      end
      ST_D2: begin
        use_src = 1'b1;
        u_div = 1'b1;
        src = t1_r;
        u_b = DW'(y_r);
      end
      ST_D3: begin
        use_src = 1'b1;
        u_div = 1'b1;
        src = k_r;
        u_b = DW'(y_r);
      end
      ST_M3: begin
        use_src = 1'b1;
        src = cur_dv;
        u_b = DW'(dt_r);
      end
      ST_M4: begin
        use_src = 1'b1;
        src = tk_r;
        u_b = DW'(e_r);
      end
      ST_M5: begin
        use_src = 1'b1;
        src = k_r;
        u_b = DW'(e_r);
      end
      ST_M6: begin
        use_src = 1'b1;
        src = j1_r;
        u_b = DW'(y_r);
      end
      ST_M7: begin
        use_src = 1'b1;
        src = tmp_r;
        u_b = DW'(dt_r);
      end
      ST_M8: begin
        use_src = 1'b1;
        src = tmp_r;
        u_b = DW'(e_r);
      end
      default: ;
    endcase

    if (use_src) begin
      u_neg = src[IW-1];
      if (u_div) begin
        u_num = {1'b0, mag47(src), 16'b0} + 64'(y_r[32:1]);
      end else begin
        u_num = 64'(mag47(src));
      end
    end

    if (is_op) begin
      if (!issued_r) begin
        u_start = 1'b1;
        issued_nxt = 1'b1;
      end else if (done_r) begin
        issued_nxt = 1'b0;
        case (state_r)
          ST_Y: begin
            y_nxt = res[32:0];
            state_nxt = ST_X;
          end
          ST_X: begin
            x_nxt = res[34:0];
            if (res >= X_MAX) begin
              e_nxt = '0;
              state_nxt = ST_J0;
            end else begin
              state_nxt = ST_X2;
            end
          end
          ST_X2: begin
            t0_nxt = res;
            state_nxt = ST_X3;
          end
          ST_X3: begin
            t1_nxt = res;
            state_nxt = ST_C1;
          end
          ST_C1: begin
            tk_nxt = res;
            state_nxt = ST_C2;
          end
          ST_C2: begin
            tmp_nxt = res;
            state_nxt = ST_DEN;
          end
          ST_E: begin
            e_nxt = res[16:0];
            state_nxt = ST_J0;
          end
          ST_M1: begin
            j1_nxt = add_sat(cur_a, res);
            state_nxt = ST_M2;
          end
          ST_M2: begin
            k_nxt = add_sat(j0_r, res);
            state_nxt = ST_D0;
          end
          ST_D0: begin
            t0_nxt = res;
            state_nxt = ST_D1;
          end
          ST_D1: begin
            t1_nxt = res;
            state_nxt = ST_D2;
          end
          ST_D2: begin
            t1_nxt = res;
            state_nxt = ST_D3;
          end
          ST_D3: begin
            tk_nxt = res;
            state_nxt = ST_M3;
          end
          ST_M3: begin
            np_nxt = add_sat(cur_p, res);
            state_nxt = ST_P1;
          end
          ST_M4: begin
            np_nxt = sub_sat(np_r, res);
            state_nxt = ST_M5;
          end
          ST_M5: begin
            nv_nxt = add_sat(res, cur_dv);
            state_nxt = ST_M6;
          end
          ST_M6: begin
            tmp_nxt = res;
            state_nxt = ST_M7;
          end
          ST_M7: begin
            tmp_nxt = sub_sat(cur_a, res);
            state_nxt = ST_M8;
          end
          ST_M8: begin
            tmp_nxt = res;
            state_nxt = ST_WB;
          end
          default: ;
        endcase
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ax_nxt = 2'd0;
            state_nxt = ST_Y;
          end
        end
        ST_DEN: begin
          den_nxt = DW'(65536) + DW'(x_r) + DW'(tk_r) + DW'(tmp_r);
          state_nxt = ST_E;
        end
        ST_J0: begin
          j0_nxt = sub_sat(cur_v, cur_dv);
          state_nxt = ST_M1;
        end
        ST_P1: begin
          np_nxt = add_sat(np_r, t1_r);
          state_nxt = ST_P2;
        end
        ST_P2: begin
          np_nxt = add_sat(np_r, t0_r);
          state_nxt = ST_P3;
        end
        ST_P3: begin
          tk_nxt = add_sat(t1_r, tk_r);
          state_nxt = ST_M4;
        end
        ST_WB: begin
          wb_en = 1'b1;
          if (ax_r == 2'd2) begin
            state_nxt = ST_OUT;
          end else begin
            ax_nxt = ax_r + 2'd1;
            state_nxt = ST_J0;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            load_out = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issued_r <= 1'b0;
      out_valid_r <= 1'b0;
      halflife_r <= HL_RESET;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      issued_r <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && paddr[2] == REG_HALFLIFE) begin
        halflife_r <= pwdata[20:0];
      end
      if (wb_en) begin
        pos_r[ax_r] <= sat32(np_r);
        vel_r[ax_r] <= sat32(nv_r);
        acc_r[ax_r] <= sat32(tmp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;
    y_r <= y_nxt;
    x_r <= x_nxt;
    e_r <= e_nxt;
    den_r <= den_nxt;
    j0_r <= j0_nxt;
    j1_r <= j1_nxt;
    k_r <= k_nxt;
    t0_r <= t0_nxt;
    t1_r <= t1_nxt;
    tk_r <= tk_nxt;
    np_r <= np_nxt;
    nv_r <= nv_nxt;
    tmp_r <= tmp_nxt;
    if (in_acc) begin
      dv_r[0] <= in_desired_vel_x;
      dv_r[1] <= in_desired_vel_y;
      dv_r[2] <= in_desired_vel_z;
      dt_r <= in_time_step;
    end
    if (load_out) begin
      for (int i = 0; i < 3; i++) begin
        opos_r[i] <= pos_r[i];
        ovel_r[i] <= vel_r[i];
        oacc_r[i] <= acc_r[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = opos_r[0];
  assign out_pos_y = opos_r[1];
  assign out_pos_z = opos_r[2];
  assign out_vel_x = ovel_r[0];
  assign out_vel_y = ovel_r[1];
  assign out_vel_z = ovel_r[2];
  assign out_acc_x = oacc_r[0];
  assign out_acc_y = oacc_r[1];
  assign out_acc_z = oacc_r[2];

endmodule
